@@ hdl/rfa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfa_pkg
// Shared types and constants of the retry frame aggregator.
// ----------------------------------------------------------------------------
package rfa_pkg;

  // field widths
  localparam int unsigned ADDR_W   = 48;
  localparam int unsigned HANDLE_W = 16;
  localparam int unsigned SEQ_W    = 12;
  localparam int unsigned TIME_W   = 64;
  localparam int unsigned TX_W     = 9;
  localparam int unsigned RETRY_W  = 8;
  localparam int unsigned KIND_W   = 2;

  // frame control codes
  localparam logic [1:0] TYPE_DATA   = 2'd2;
  localparam logic [3:0] SUBTYPE_ACK = 4'd13;

  // group bit of the first octet of an address
  localparam int unsigned GROUP_BIT = 40;

  // transmission count ceiling
  localparam logic [TX_W-1:0] TX_MAX = 9'd256;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_PASS = 2'd0;
  localparam logic [KIND_W-1:0] KIND_AGG  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic load_item;   // capture the input request
    logic start_run;   // open a new aggregate from the held frame
    logic retry_upd;   // absorb a retry
    logic ack_upd;     // absorb an ack
    logic enqueue;     // park the held frame in the side queue
    logic q_clear;     // drop queue contents, rewind read pointer
    logic end_clear;   // leave aggregating mode
    logic emit_agg;    // load the aggregate into the output register
    logic emit_item;   // load the held frame as a pass-through
    logic emit_none;   // load a no-frame result
    logic emit_queue;  // load the current queue entry
    logic last;        // last result of this request
  } rfa_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_end;
    logic qualifies;
    logic aggregating;
    logic same_seq;
    logic is_ack;
    logic q_full;
    logic q_empty;
    logic q_last;
    logic out_free;
  } rfa_status_t;

endpackage

@@ hdl/retry_frame_aggregator_top.sv @@
`timescale 1ns / 1ps
// a request is taken in the idle state and evaluated; its results then go from S_ONE,
//   S_AGG or S_DRAIN into the output register, one a cycle while it is free;
//   no request is taken till the last is loaded; one with no result ends in evaluation
// the side queue drains one entry a cycle (output free) via its registered read port
// reset (synchronous, rst_n low) clears run state, queue fill and handshake state;
//   queue storage is not cleared and needs no clearing pass
// ----------------------------------------------------------------------------
// retry_frame_aggregator_top
// Merges retried unicast data frames of one transmitter into aggregate results.
// ----------------------------------------------------------------------------
module retry_frame_aggregator_top #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [3:0]                    paddr,
  input  logic [63:0]                   pwdata,
  output logic [63:0]                   prdata,
  output logic                          pready,
  // request channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_func,
  input  logic [rfa_pkg::HANDLE_W-1:0]  in_frame_handle,
  input  logic [1:0]                    in_frame_type,
  input  logic [3:0]                    in_frame_subtype,
  input  logic [rfa_pkg::ADDR_W-1:0]    in_receiver_addr,
  input  logic [rfa_pkg::ADDR_W-1:0]    in_sender_addr,
  input  logic [rfa_pkg::SEQ_W-1:0]     in_seq_number,
  input  logic [rfa_pkg::TIME_W-1:0]    in_end_time,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rfa_pkg::KIND_W-1:0]    out_kind,
  output logic [rfa_pkg::HANDLE_W-1:0]  out_out_handle,
  output logic [rfa_pkg::RETRY_W-1:0]   out_retry_count,
  output logic [rfa_pkg::TIME_W-1:0]    out_last_end_time,
  output logic                          out_last_of_run
);

  logic [rfa_pkg::ADDR_W-1:0] station_r;
  logic                       reg_sel;
  rfa_pkg::rfa_cmd_t          cmd;
  rfa_pkg::rfa_status_t       sts;

  // register decode, station address at byte address 0
  assign reg_sel = !paddr[3];
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? {16'd0, station_r} : 64'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      station_r <= '0;
    end else if (psel && penable && pwrite && reg_sel) begin
      station_r <= pwdata[rfa_pkg::ADDR_W-1:0];
    end
  end

  // sequencer
  rfa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  rfa_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .station_addr      (station_r),
    .cmd               (cmd),
    .sts               (sts),
    .in_func           (in_func),
    .in_frame_handle   (in_frame_handle),
    .in_frame_type     (in_frame_type),
    .in_frame_subtype  (in_frame_subtype),
    .in_receiver_addr  (in_receiver_addr),
    .in_sender_addr    (in_sender_addr),
    .in_seq_number     (in_seq_number),
    .in_end_time       (in_end_time),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_out_handle    (out_out_handle),
    .out_retry_count   (out_retry_count),
    .out_last_end_time (out_last_end_time),
    .out_last_of_run   (out_last_of_run)
  );

endmodule

@@ hdl/rfa_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfa_ctrl
// Sequencer: classifies each request and walks the result sequence.
// ----------------------------------------------------------------------------
module rfa_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rfa_pkg::rfa_status_t sts,
  output rfa_pkg::rfa_cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EVAL  = 5'b00010,
    S_AGG   = 5'b00100,
    S_DRAIN = 5'b01000,
    S_ONE   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   restart_r, restart_nxt;  // after the aggregate, open a new run
  logic   none_r, none_nxt;        // single result is a no-frame result

  assign in_ready = (state_r == S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    restart_nxt = restart_r;
    none_nxt    = none_r;
    cmd         = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_EVAL;
        end
      end
      S_EVAL: begin
        if (sts.is_end) begin
          if (sts.aggregating) begin
            restart_nxt = 1'b0;
            state_nxt   = S_AGG;
          end else begin
            none_nxt  = 1'b1;
            state_nxt = S_ONE;
          end
        end else if (!sts.aggregating) begin
          if (sts.qualifies) begin
            cmd.start_run = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            none_nxt  = 1'b0;
            state_nxt = S_ONE;
          end
        end else if (sts.qualifies) begin
          if (sts.same_seq) begin
            cmd.retry_upd = 1'b1;
            cmd.q_clear   = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            restart_nxt = 1'b1;
            state_nxt   = S_AGG;
          end
        end else if (sts.is_ack) begin
          cmd.ack_upd = 1'b1;
          cmd.q_clear = 1'b1;
          state_nxt   = S_IDLE;
        end else if (!sts.q_full) begin
          cmd.enqueue = 1'b1;
          state_nxt   = S_IDLE;
        end else begin
          none_nxt  = 1'b0;
          state_nxt = S_ONE;
        end
      end
      S_AGG: begin
        if (sts.out_free) begin
          cmd.emit_agg  = 1'b1;
          cmd.last      = sts.q_empty;
          cmd.start_run = restart_r;
          cmd.end_clear = !restart_r;
          state_nxt     = sts.q_empty ? S_IDLE : S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (sts.out_free) begin
          cmd.emit_queue = 1'b1;
          cmd.last       = sts.q_last;
          if (sts.q_last) begin
            cmd.q_clear = 1'b1;
            state_nxt   = S_IDLE;
          end
        end
      end
      S_ONE: begin
        if (sts.out_free) begin
          cmd.emit_none = none_r;
          cmd.emit_item = !none_r;
          cmd.last      = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      restart_r <= 1'b0;
      none_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      restart_r <= restart_nxt;
      none_r    <= none_nxt;
    end
  end

endmodule

@@ hdl/rfa_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfa_dp
// Datapath: request register, run state, side queue and output register.
// ----------------------------------------------------------------------------
module rfa_dp #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [rfa_pkg::ADDR_W-1:0]    station_addr,
  input  rfa_pkg::rfa_cmd_t             cmd,
  output rfa_pkg::rfa_status_t          sts,
  input  logic                          in_func,
  input  logic [rfa_pkg::HANDLE_W-1:0]  in_frame_handle,
  input  logic [1:0]                    in_frame_type,
  input  logic [3:0]                    in_frame_subtype,
  input  logic [rfa_pkg::ADDR_W-1:0]    in_receiver_addr,
  input  logic [rfa_pkg::ADDR_W-1:0]    in_sender_addr,
  input  logic [rfa_pkg::SEQ_W-1:0]     in_seq_number,
  input  logic [rfa_pkg::TIME_W-1:0]    in_end_time,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rfa_pkg::KIND_W-1:0]    out_kind,
  output logic [rfa_pkg::HANDLE_W-1:0]  out_out_handle,
  output logic [rfa_pkg::RETRY_W-1:0]   out_retry_count,
  output logic [rfa_pkg::TIME_W-1:0]    out_last_end_time,
  output logic                          out_last_of_run
);

  localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(QUEUE_DEPTH);

  // held request
  logic                         func_r;
  logic [rfa_pkg::HANDLE_W-1:0] handle_r;
  logic [1:0]                   type_r;
  logic [3:0]                   sub_r;
  logic [rfa_pkg::ADDR_W-1:0]   ra_r;
  logic [rfa_pkg::ADDR_W-1:0]   ta_r;
  logic [rfa_pkg::SEQ_W-1:0]    seq_r;
  logic [rfa_pkg::TIME_W-1:0]   time_r;

  // run state
  logic                         agg_r;
  logic [rfa_pkg::SEQ_W-1:0]    held_seq_r;
  logic [rfa_pkg::HANDLE_W-1:0] first_handle_r;
  logic [rfa_pkg::TIME_W-1:0]   latest_time_r;
  logic [rfa_pkg::TX_W-1:0]     tx_r;

  // side queue
  logic [rfa_pkg::HANDLE_W-1:0] queue_mem [QUEUE_DEPTH];
  logic [rfa_pkg::HANDLE_W-1:0] q_rdata_r;
  logic [FILL_W-1:0]            fill_r;
  logic [PTR_W-1:0]             rd_ptr_r, rd_ptr_nxt;

  // output register
  logic                         ovalid_r;
  logic [rfa_pkg::KIND_W-1:0]   okind_r;
  logic [rfa_pkg::HANDLE_W-1:0] ohandle_r;
  logic [rfa_pkg::RETRY_W-1:0]  oretry_r;
  logic [rfa_pkg::TIME_W-1:0]   otime_r;
  logic                         olast_r;

  logic [rfa_pkg::RETRY_W-1:0]  retry_val;
  logic                         any_emit;

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      func_r   <= in_func;
      handle_r <= in_frame_handle;
      type_r   <= in_frame_type;
      sub_r    <= in_frame_subtype;
      ra_r     <= in_receiver_addr;
      ta_r     <= in_sender_addr;
      seq_r    <= in_seq_number;
      time_r   <= in_end_time;
    end
  end

  // classification of the held request
  always_comb begin
    sts.is_end      = func_r;
    sts.qualifies   = (type_r == rfa_pkg::TYPE_DATA) && (ta_r == station_addr) &&
                      !ra_r[rfa_pkg::GROUP_BIT];
    sts.aggregating = agg_r;
    sts.same_seq    = (seq_r == held_seq_r);
    sts.is_ack      = (sub_r == rfa_pkg::SUBTYPE_ACK) && (ra_r == station_addr);
    sts.q_full      = (fill_r == FILL_MAX);
    sts.q_empty     = (fill_r == '0);
    sts.q_last      = ((FILL_W'(rd_ptr_r) + FILL_W'(1)) == fill_r);
    sts.out_free    = !ovalid_r || out_ready;
  end

  // run state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      agg_r          <= 1'b0;
      held_seq_r     <= '0;
      first_handle_r <= '0;
      latest_time_r  <= '0;
      tx_r           <= '0;
    end else if (cmd.start_run) begin
      agg_r          <= 1'b1;
      held_seq_r     <= seq_r;
      first_handle_r <= handle_r;
      latest_time_r  <= time_r;
      tx_r           <= rfa_pkg::TX_W'(1);
    end else if (cmd.end_clear) begin
      agg_r          <= 1'b0;
      held_seq_r     <= '0;
      first_handle_r <= '0;
      latest_time_r  <= '0;
      tx_r           <= '0;
    end else if (cmd.retry_upd) begin
      latest_time_r <= time_r;
      if (tx_r != rfa_pkg::TX_MAX) begin
        tx_r <= tx_r + rfa_pkg::TX_W'(1);
      end
    end else if (cmd.ack_upd) begin
      latest_time_r <= time_r;
    end
  end

  // queue fill and read pointer
  always_comb begin
    rd_ptr_nxt = rd_ptr_r;
    if (cmd.q_clear) begin
      rd_ptr_nxt = '0;
    end else if (cmd.emit_queue) begin
      rd_ptr_nxt = rd_ptr_r + PTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= '0;
      rd_ptr_r <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      if (cmd.q_clear) begin
        fill_r <= '0;
      end else if (cmd.enqueue) begin
        fill_r <= fill_r + FILL_W'(1);
      end
    end
  end

  // queue storage, read data is registered from the next pointer so it matches the pointer
  always_ff @(posedge clk) begin
    if (cmd.enqueue) begin
      queue_mem[fill_r[PTR_W-1:0]] <= handle_r;
    end
    q_rdata_r <= queue_mem[rd_ptr_nxt];
  end

  // saturated retry count of the open run
  assign retry_val = tx_r[rfa_pkg::TX_W-1] ? {rfa_pkg::RETRY_W{1'b1}}
                                           : (tx_r[rfa_pkg::RETRY_W-1:0] -
                                              rfa_pkg::RETRY_W'(1));

  assign any_emit = cmd.emit_agg || cmd.emit_item || cmd.emit_none || cmd.emit_queue;

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (any_emit) begin
      ovalid_r <= 1'b1;
    end else if (out_ready) begin
      ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (any_emit) begin
      olast_r <= cmd.last;
      if (cmd.emit_agg) begin
        okind_r   <= rfa_pkg::KIND_AGG;
        ohandle_r <= first_handle_r;
        oretry_r  <= retry_val;
        otime_r   <= latest_time_r;
      end else if (cmd.emit_queue) begin
        okind_r   <= rfa_pkg::KIND_PASS;
        ohandle_r <= q_rdata_r;
        oretry_r  <= '0;
        otime_r   <= '0;
      end else if (cmd.emit_item) begin
        okind_r   <= rfa_pkg::KIND_PASS;
        ohandle_r <= handle_r;
        oretry_r  <= '0;
        otime_r   <= '0;
      end else begin
        okind_r   <= rfa_pkg::KIND_NONE;
        ohandle_r <= '0;
        oretry_r  <= '0;
        otime_r   <= '0;
      end
    end
  end

  assign out_valid         = ovalid_r;
  assign out_kind          = okind_r;
  assign out_out_handle    = ohandle_r;
  assign out_retry_count   = oretry_r;
  assign out_last_end_time = otime_r;
  assign out_last_of_run   = olast_r;

  // queue never overfills
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_MAX)
    else $error("side queue fill beyond depth");

  // a run is open exactly when a transmission is counted
  a_run_count: assert property (@(posedge clk) disable iff (!rst_n)
    agg_r == (tx_r != '0))
    else $error("aggregating flag and transmission count disagree");

  // enqueue only into a queue with room
  a_enq_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.enqueue |-> (fill_r < FILL_MAX))
    else $error("enqueue into full side queue");

  // drain reads only filled entries
  a_drain_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_queue |-> (FILL_W'(rd_ptr_r) < fill_r))
    else $error("drain beyond queue fill");

  // a new result is loaded only into a free output register
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    any_emit |-> (!ovalid_r || out_ready))
    else $error("result overwrites pending output");

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the retry frame aggregator. Frame requests go out
// from a queue through a valid/ready driver with random gaps. Each accepted
// request runs through a local merge predictor that builds the results the
// block owes. A monitor with random backpressure compares every result
// against the oldest one still awaited. The station address is rewritten
// over the APB port between phases, with both extremes among the settings.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned QDEPTH         = 16;
  localparam int unsigned DRAIN_CYCLES   = 10;
  localparam int unsigned TIMEOUT_CYCLES = 200000;
  localparam int unsigned IDLE_PCT       = 24;
  localparam int unsigned MAX_REPORTS    = 10;

  // register map
  localparam logic [3:0] REG_STATION_ADDR = 4'd0;

  localparam logic [rfa_pkg::ADDR_W-1:0] DIRECT_STATION = 48'h021A_2B3C_4D5E;

  typedef struct packed {
    logic                         func;
    logic [rfa_pkg::HANDLE_W-1:0] handle;
    logic [1:0]                   ftype;
    logic [3:0]                   fsub;
    logic [rfa_pkg::ADDR_W-1:0]   ra;
    logic [rfa_pkg::ADDR_W-1:0]   ta;
    logic [rfa_pkg::SEQ_W-1:0]    seq;
    logic [rfa_pkg::TIME_W-1:0]   t;
  } frame_req_t;

  typedef struct packed {
    logic [rfa_pkg::KIND_W-1:0]   kind;
    logic [rfa_pkg::HANDLE_W-1:0] handle;
    logic [rfa_pkg::RETRY_W-1:0]  retry;
    logic [rfa_pkg::TIME_W-1:0]   t;
    logic                         last;
  } frame_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [3:0]                   paddr = '0;
  logic [63:0]                  pwdata = '0;
  logic [63:0]                  prdata;
  logic                         pready;

  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic                         in_func = 1'b0;
  logic [rfa_pkg::HANDLE_W-1:0] in_frame_handle = '0;
  logic [1:0]                   in_frame_type = '0;
  logic [3:0]                   in_frame_subtype = '0;
  logic [rfa_pkg::ADDR_W-1:0]   in_receiver_addr = '0;
  logic [rfa_pkg::ADDR_W-1:0]   in_sender_addr = '0;
  logic [rfa_pkg::SEQ_W-1:0]    in_seq_number = '0;
  logic [rfa_pkg::TIME_W-1:0]   in_end_time = '0;

  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [rfa_pkg::KIND_W-1:0]   out_kind;
  logic [rfa_pkg::HANDLE_W-1:0] out_out_handle;
  logic [rfa_pkg::RETRY_W-1:0]  out_retry_count;
  logic [rfa_pkg::TIME_W-1:0]   out_last_end_time;
  logic                         out_last_of_run;

  retry_frame_aggregator_top #(
    .QUEUE_DEPTH(QDEPTH)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_func(in_func),
    .in_frame_handle(in_frame_handle),
    .in_frame_type(in_frame_type),
    .in_frame_subtype(in_frame_subtype),
    .in_receiver_addr(in_receiver_addr),
    .in_sender_addr(in_sender_addr),
    .in_seq_number(in_seq_number),
    .in_end_time(in_end_time),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_kind(out_kind),
    .out_out_handle(out_out_handle),
    .out_retry_count(out_retry_count),
    .out_last_end_time(out_last_end_time),
    .out_last_of_run(out_last_of_run)
  );

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  frame_req_t    frames_to_send[$];
  frame_result_t awaited_results[$];
  frame_req_t    cur_frame = '0;
  int unsigned   frames_queued = 0;
  int unsigned   frames_taken = 0;
  int unsigned   errors = 0;
  int unsigned   cycles = 0;
  logic          calm = 1'b0;

  // shadow of the station register and of the merge state
  logic [rfa_pkg::ADDR_W-1:0]   station_cfg = '0;
  logic                         run_open = 1'b0;
  logic [rfa_pkg::SEQ_W-1:0]    run_seq = '0;
  logic [rfa_pkg::HANDLE_W-1:0] run_handle = '0;
  logic [rfa_pkg::TIME_W-1:0]   run_time = '0;
  logic [rfa_pkg::TX_W-1:0]     run_tx = '0;
  logic [rfa_pkg::HANDLE_W-1:0] held_handles[QDEPTH];
  int unsigned                  held_fill = 0;

  function automatic void expect_result(logic [rfa_pkg::KIND_W-1:0] kind,
                                        logic [rfa_pkg::HANDLE_W-1:0] handle,
                                        logic [rfa_pkg::RETRY_W-1:0] retry,
                                        logic [rfa_pkg::TIME_W-1:0] t);
    frame_result_t r;
    r.kind = kind;
    r.handle = handle;
    r.retry = retry;
    r.t = t;
    r.last = 1'b0;
    awaited_results.insert(awaited_results.size(), r);
  endfunction

  // aggregate of the open run, then the parked frames in arrival order
  function automatic void release_run();
    logic [rfa_pkg::RETRY_W-1:0] retry;
    if (run_tx == '0)
      retry = '0;
    else if (run_tx - 1'b1 > 9'd255)
      retry = 8'd255;
    else
      retry = 8'(run_tx - 1'b1);
    expect_result(rfa_pkg::KIND_AGG, run_handle, retry, run_time);
    for (int unsigned i = 0; i < held_fill; i++)
      expect_result(rfa_pkg::KIND_PASS, held_handles[i], '0, '0);
    held_fill = 0;
  endfunction

  // results owed for one accepted request
  function automatic void merge_frame(frame_req_t f);
    logic          qual;
    int unsigned   n0;
    int unsigned   idx;
    frame_result_t tail;
    n0 = awaited_results.size();
    if (f.func) begin
      if (run_open) begin
        release_run();
        run_open = 1'b0;
        run_seq = '0;
        run_handle = '0;
        run_time = '0;
        run_tx = '0;
      end else begin
        expect_result(rfa_pkg::KIND_NONE, '0, '0, '0);
      end
    end else begin
      qual = (f.ftype == rfa_pkg::TYPE_DATA) && (f.ta == station_cfg) &&
             !f.ra[rfa_pkg::GROUP_BIT];
      if (!run_open) begin
        if (qual) begin
          run_open = 1'b1;
          run_seq = f.seq;
          run_handle = f.handle;
          run_time = f.t;
          run_tx = 9'd1;
          held_fill = 0;
        end else begin
          expect_result(rfa_pkg::KIND_PASS, f.handle, '0, '0);
        end
      end else if (qual) begin
        if (f.seq == run_seq) begin
          run_time = f.t;
          if (run_tx < rfa_pkg::TX_MAX)
            run_tx = run_tx + 1'b1;
          held_fill = 0;
        end else begin
          release_run();
          run_seq = f.seq;
          run_handle = f.handle;
          run_time = f.t;
          run_tx = 9'd1;
        end
      end else if (f.fsub == rfa_pkg::SUBTYPE_ACK && f.ra == station_cfg) begin
        run_time = f.t;
        held_fill = 0;
      end else if (held_fill < QDEPTH) begin
        held_handles[held_fill] = f.handle;
        held_fill++;
      end else begin
        expect_result(rfa_pkg::KIND_PASS, f.handle, '0, '0);
      end
    end
    // flag the final result of this request
    if (awaited_results.size() > n0) begin
      idx = awaited_results.size() - 1;
      tail = awaited_results[idx];
      tail.last = 1'b1;
      awaited_results[idx] = tail;
    end
  endfunction

  // request driver
  always @(posedge clk) begin : frame_driver
    frame_req_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        merge_frame(cur_frame);
        frames_taken++;
      end
      if (!in_valid || in_ready) begin
        if (frames_to_send.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          nxt = frames_to_send[0];
          frames_to_send.delete(0);
          cur_frame <= nxt;
          in_func <= nxt.func;
          in_frame_handle <= nxt.handle;
          in_frame_type <= nxt.ftype;
          in_frame_subtype <= nxt.fsub;
          in_receiver_addr <= nxt.ra;
          in_sender_addr <= nxt.ta;
          in_seq_number <= nxt.seq;
          in_end_time <= nxt.t;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random backpressure
  always @(posedge clk) begin : result_monitor
    frame_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("unexpected result: kind %0d handle %h retry %0d time %h last %b",
                     out_kind, out_out_handle, out_retry_count, out_last_end_time,
                     out_last_of_run);
        end else begin
          want = awaited_results[0];
          awaited_results.delete(0);
          if (out_kind !== want.kind || out_out_handle !== want.handle ||
              out_retry_count !== want.retry || out_last_end_time !== want.t ||
              out_last_of_run !== want.last) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
              $display("result mismatch: exp kind %0d handle %h retry %0d time %h last %b",
                       want.kind, want.handle, want.retry, want.t, want.last);
              $display("                 got kind %0d handle %h retry %0d time %h last %b",
                       out_kind, out_out_handle, out_retry_count, out_last_end_time,
                       out_last_of_run);
            end
          end
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles >= TIMEOUT_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic frame_req_t mk_frame(logic func, logic [rfa_pkg::HANDLE_W-1:0] handle,
                                          logic [1:0] ftype, logic [3:0] fsub,
                                          logic [rfa_pkg::ADDR_W-1:0] ra,
                                          logic [rfa_pkg::ADDR_W-1:0] ta,
                                          logic [rfa_pkg::SEQ_W-1:0] seq,
                                          logic [rfa_pkg::TIME_W-1:0] t);
    frame_req_t f;
    f.func = func;
    f.handle = handle;
    f.ftype = ftype;
    f.fsub = fsub;
    f.ra = ra;
    f.ta = ta;
    f.seq = seq;
    f.t = t;
    return f;
  endfunction

  // unicast data frame from the configured station
  function automatic frame_req_t station_frame(logic [rfa_pkg::SEQ_W-1:0] seq);
    frame_req_t f;
    f = mk_frame(1'b0, 16'($urandom), rfa_pkg::TYPE_DATA, 4'($urandom), 48'(rand64()),
                 station_cfg, seq, rand64());
    f.ra[rfa_pkg::GROUP_BIT] = 1'b0;
    return f;
  endfunction

  function automatic frame_req_t ack_frame();
    return mk_frame(1'b0, 16'($urandom), 2'($urandom), rfa_pkg::SUBTYPE_ACK, station_cfg,
                    48'(rand64()), 12'($urandom), rand64());
  endfunction

  function automatic frame_req_t noise_frame();
    return mk_frame(1'b0, 16'($urandom), 2'($urandom), 4'($urandom), 48'(rand64()),
                    48'(rand64()), 12'($urandom), rand64());
  endfunction

  // from the station but group addressed or not data
  function automatic frame_req_t near_miss();
    frame_req_t f;
    f = station_frame(12'($urandom));
    if ($urandom_range(1))
      f.ra[rfa_pkg::GROUP_BIT] = 1'b1;
    else
      f.ftype = $urandom_range(1) ? 2'd3 : 2'($urandom_range(1));
    return f;
  endfunction

  function automatic frame_req_t end_frame();
    frame_req_t f;
    f = noise_frame();
    f.func = 1'b1;
    return f;
  endfunction

  function automatic void send(frame_req_t f);
    frames_to_send.insert(frames_to_send.size(), f);
    frames_queued++;
  endfunction

  // random runs: mostly well-formed retry runs, some noise and broken runs
  function automatic void random_mix(int unsigned count);
    int unsigned               n;
    int unsigned               len;
    int unsigned               sel;
    logic [rfa_pkg::SEQ_W-1:0] seq;
    n = 0;
    while (n < count) begin
      sel = $urandom_range(99);
      if (sel < 8) begin
        send(end_frame());
        n++;
      end else if (sel < 14) begin
        send(noise_frame());
        n++;
      end else if (sel < 18) begin
        send(near_miss());
        n++;
      end else begin
        seq = 12'($urandom);
        send(station_frame(seq));
        n++;
        if ($urandom_range(9) == 0) begin
          // long unrelated stretch that can overrun the side queue
          len = $urandom_range(20, 14);
          for (int unsigned j = 0; j < len; j++)
            send(noise_frame());
        end else begin
          len = $urandom_range(8);
          for (int unsigned j = 0; j < len; j++) begin
            sel = $urandom_range(99);
            if (sel < 25)
              send(station_frame(seq));
            else if (sel < 40)
              send(ack_frame());
            else if (sel < 50)
              send(near_miss());
            else
              send(noise_frame());
          end
        end
        n += len;
        if ($urandom_range(3) == 0) begin
          send(end_frame());
          n++;
        end
      end
    end
  endfunction

  task automatic write_station(logic [rfa_pkg::ADDR_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_STATION_ADDR;
    pwdata <= {16'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready)
      @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    station_cfg = value;
  endtask

  // wait until every request is taken and every result has come back
  task automatic wait_quiet();
    @(posedge clk);
    while (frames_taken != frames_queued || awaited_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [rfa_pkg::ADDR_W-1:0] addr;
    logic [rfa_pkg::SEQ_W-1:0]  seq;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: idle cases, retries, acks, queue overrun, end of input
    write_station(DIRECT_STATION);
    send(mk_frame(1'b1, '1, '1, '1, '1, '1, '1, '1));
    send(mk_frame(1'b0, '0, '0, '0, '0, '0, '0, '0));
    send(mk_frame(1'b0, '1, '1, '1, '1, '1, '1, '1));
    send(ack_frame());
    send(near_miss());
    send(mk_frame(1'b0, 16'h1234, rfa_pkg::TYPE_DATA, 4'd0, 48'h0, DIRECT_STATION, 12'hFFF,
                  64'd0));
    send(noise_frame());
    send(mk_frame(1'b0, 16'h5678, rfa_pkg::TYPE_DATA, 4'd8, 48'h00AA_0000_0001,
                  DIRECT_STATION, 12'hFFF, '1));
    send(noise_frame());
    // ack that looks like data: only subtype and receiver decide
    send(mk_frame(1'b0, 16'h9ABC, rfa_pkg::TYPE_DATA, rfa_pkg::SUBTYPE_ACK, DIRECT_STATION,
                  48'h0000_0000_0001, 12'h001, 64'h0123_4567_89AB_CDEF));
    send(noise_frame());
    send(mk_frame(1'b0, '1, rfa_pkg::TYPE_DATA, 4'd0, 48'hFEFF_FFFF_FFFF, DIRECT_STATION,
                  12'h000, 64'h8000_0000_0000_0000));
    for (int i = 0; i < QDEPTH + 1; i++)
      send(noise_frame());
    send(end_frame());
    send(end_frame());
    wait_quiet();

    // reset-value station
    write_station('0);
    random_mix(8);
    wait_quiet();

    // all-ones station, no idling on either side
    calm = 1'b1;
    write_station('1);
    random_mix(8);
    wait_quiet();
    calm = 1'b0;

    addr = 48'(rand64());
    addr[rfa_pkg::GROUP_BIT] = 1'b0;
    write_station(addr);
    random_mix(8);
    wait_quiet();

    // one long run, no idling, to saturate the retry count
    calm = 1'b1;
    write_station(48'(rand64()));
    seq = 12'($urandom);
    send(station_frame(seq));
    for (int i = 0; i < 256; i++) begin
      send(station_frame(seq));
      if (i == 100)
        send(noise_frame());
    end
    send(noise_frame());
    send(end_frame());
    wait_quiet();
    calm = 1'b0;

    if (errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/rfa_pkg.sv
hdl/rfa_ctrl.sv
hdl/rfa_dp.sv
hdl/retry_frame_aggregator_top.sv
sim/tb.sv
